FILE: sv/largest_island_after_one_flip_macros.svh
// Assertion helpers for the island block.
`ifndef LARGEST_ISLAND_AFTER_ONE_FLIP_MACROS_SVH
`define LARGEST_ISLAND_AFTER_ONE_FLIP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define LIA_CHECK(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication.
`define LIA_CHECK_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: sv/lia_pkg.sv
package lia_pkg;

   // Image geometry
   localparam int MAX_SIDE   = 32;
   localparam int CELLS      = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W     = $clog2(CELLS);
   localparam int CNT_W      = $clog2(CELLS + 1);
   localparam int SIZE_W     = CNT_W;
   localparam int NW         = $clog2(MAX_SIDE + 1);
   localparam int SIDE_W     = 6;
   localparam int OUT_W      = 11;
   localparam int SIDE_RESET = 32;

   // Neighbor directions: up, right, down, left
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   // Datapath commands
   typedef enum logic [4:0] {
      C_NONE,
      C_LOAD,
      C_LOADLAST,
      C_INIT,
      C_NEXT,
      C_RD_HERE_U,
      C_RD_HERE_E,
      C_KINC,
      C_RD_NB,
      C_FIND_HERE,
      C_HOP,
      C_SAVE_A,
      C_SIZE_A,
      C_SIZE_B,
      C_LINK,
      C_FIND_NB,
      C_SIZE_R,
      C_ADD,
      C_FIN,
      C_RD_SCAN,
      C_SCAN_CMP,
      C_EMIT
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
   } ctrl_type;

   typedef struct packed {
      logic       last_pix;
      logic       cell_last;
      logic       img_bit;
      logic       nb_ok;
      logic [1:0] k;
      logic       found;
      logic       same;
      logic       dup;
      logic       out_free;
   } status_type;

endpackage

FILE: sv/lia_ctrl.sv
module lia_ctrl import lia_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type stat,
   output ctrl_type   ctrl
);

   typedef enum logic [4:0] {
      ST_LOAD, ST_INIT,
      ST_U_IMG, ST_U_HCHK, ST_U_NB, ST_U_NCHK, ST_U_FA, ST_U_FB, ST_U_SA, ST_U_LINK,
      ST_U_KEND,
      ST_E_IMG, ST_E_HCHK, ST_E_NB, ST_E_NCHK, ST_E_F, ST_E_ADD, ST_E_KEND,
      ST_S_RD, ST_S_CHK, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   cmd_type   cmd;

   assign req_ready = (state_ff == ST_LOAD);
   assign ctrl.cmd  = cmd;

   // Next state and command
   always_comb begin
      state_in = state_ff;
      cmd      = C_NONE;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (stat.last_pix) begin
                  cmd      = C_LOADLAST;
                  state_in = ST_INIT;
               end else begin
                  cmd = C_LOAD;
               end
            end
         end
         ST_INIT: begin
            cmd = C_INIT;
            if (stat.cell_last) state_in = ST_U_IMG;
         end
         // union pass: right and down neighbors of each land cell
         ST_U_IMG: begin
            cmd      = C_RD_HERE_U;
            state_in = ST_U_HCHK;
         end
         ST_U_HCHK: begin
            if (stat.img_bit) begin
               state_in = ST_U_NB;
            end else begin
               cmd      = C_NEXT;
               state_in = stat.cell_last ? ST_E_IMG : ST_U_IMG;
            end
         end
         ST_U_NB: begin
            if (stat.nb_ok) begin
               cmd      = C_RD_NB;
               state_in = ST_U_NCHK;
            end else begin
               state_in = ST_U_KEND;
            end
         end
         ST_U_NCHK: begin
            if (stat.img_bit) begin
               cmd      = C_FIND_HERE;
               state_in = ST_U_FA;
            end else begin
               state_in = ST_U_KEND;
            end
         end
         ST_U_FA: begin
            if (stat.found) begin
               cmd      = C_SAVE_A;
               state_in = ST_U_FB;
            end else begin
               cmd = C_HOP;
            end
         end
         ST_U_FB: begin
            if (stat.found) begin
               cmd      = C_SIZE_A;
               state_in = ST_U_SA;
            end else begin
               cmd = C_HOP;
            end
         end
         ST_U_SA: begin
            if (stat.same) begin
               state_in = ST_U_KEND;
            end else begin
               cmd      = C_SIZE_B;
               state_in = ST_U_LINK;
            end
         end
         ST_U_LINK: begin
            cmd      = C_LINK;
            state_in = ST_U_KEND;
         end
         ST_U_KEND: begin
            if (stat.k == DIR_DOWN) begin
               cmd      = C_NEXT;
               state_in = stat.cell_last ? ST_E_IMG : ST_U_IMG;
            end else begin
               cmd      = C_KINC;
               state_in = ST_U_NB;
            end
         end
         // flip pass: water cells sum distinct neighbor components
         ST_E_IMG: begin
            cmd      = C_RD_HERE_E;
            state_in = ST_E_HCHK;
         end
         ST_E_HCHK: begin
            if (stat.img_bit) begin
               cmd      = C_NEXT;
               state_in = stat.cell_last ? ST_S_RD : ST_E_IMG;
            end else begin
               state_in = ST_E_NB;
            end
         end
         ST_E_NB: begin
            if (stat.nb_ok) begin
               cmd      = C_RD_NB;
               state_in = ST_E_NCHK;
            end else begin
               state_in = ST_E_KEND;
            end
         end
         ST_E_NCHK: begin
            if (stat.img_bit) begin
               cmd      = C_FIND_NB;
               state_in = ST_E_F;
            end else begin
               state_in = ST_E_KEND;
            end
         end
         ST_E_F: begin
            if (stat.found) begin
               if (stat.dup) begin
                  state_in = ST_E_KEND;
               end else begin
                  cmd      = C_SIZE_R;
                  state_in = ST_E_ADD;
               end
            end else begin
               cmd = C_HOP;
            end
         end
         ST_E_ADD: begin
            cmd      = C_ADD;
            state_in = ST_E_KEND;
         end
         ST_E_KEND: begin
            if (stat.k == DIR_LEFT) begin
               cmd      = C_FIN;
               state_in = stat.cell_last ? ST_S_RD : ST_E_IMG;
            end else begin
               cmd      = C_KINC;
               state_in = ST_E_NB;
            end
         end
         // root scan for the no-flip case
         ST_S_RD: begin
            cmd      = C_RD_SCAN;
            state_in = ST_S_CHK;
         end
         ST_S_CHK: begin
            cmd      = C_SCAN_CMP;
            state_in = stat.cell_last ? ST_OUT : ST_S_RD;
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd      = C_EMIT;
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else       state_ff <= state_in;
   end

endmodule

FILE: sv/lia_dp.sv
module lia_dp import lia_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [SIDE_W-1:0]  csr_write_data,
   input  logic               req_pixel,
   input  logic               rsp_ready,
   input  ctrl_type           ctrl,
   output status_type         stat,
   output logic               rsp_valid,
   output logic [OUT_W-1:0]   rsp_largest_size
);

   // Memories
   logic              img_mem [CELLS];
   logic [ADDR_W-1:0] par_mem [CELLS];
   logic [SIZE_W-1:0] siz_mem [CELLS];
   logic              img_q;
   logic [ADDR_W-1:0] par_q;
   logic [SIZE_W-1:0] siz_q;

   logic [SIDE_W-1:0] side_ff;
   logic [ADDR_W-1:0] pcount_ff, cell_ff, cur_ff, ra_ff, rb_ff;
   logic [NW-1:0]     row_ff, col_ff;
   logic [1:0]        k_ff;
   logic [SIZE_W-1:0] sa_ff, sum_ff, best_ff;
   logic [ADDR_W-1:0] seen_ff [4];
   logic [2:0]        seen_cnt_ff;
   logic              rsp_valid_ff;
   logic [OUT_W-1:0]  rsp_data_ff;

   logic [NW-1:0]     side_n, n_m1;
   logic [CNT_W-1:0]  n_wide, total, last_idx;
   logic [ADDR_W-1:0] n_a, nb_addr;
   logic              nb_ok, dup, advance;
   logic [ADDR_W-1:0] img_raddr, par_raddr, siz_raddr;
   logic [ADDR_W-1:0] small_root, big_root;
   logic [SIZE_W-1:0] link_sum;
   cmd_type           cmd;

   assign cmd = ctrl.cmd;

   // Effective side, clamped to 1..MAX_SIDE
   always_comb begin
      if (side_ff == '0)                      side_n = NW'(1);
      else if (32'(side_ff) > MAX_SIDE)       side_n = NW'(MAX_SIDE);
      else                                    side_n = NW'(side_ff);
   end
   assign n_m1     = side_n - NW'(1);
   assign n_wide   = CNT_W'(side_n);
   assign total    = n_wide * n_wide;
   assign last_idx = total - CNT_W'(1);
   assign n_a      = ADDR_W'(side_n);

   // Neighbor address and bounds
   always_comb begin
      case (k_ff)
         DIR_UP: begin
            nb_ok   = (row_ff != '0);
            nb_addr = cell_ff - n_a;
         end
         DIR_RIGHT: begin
            nb_ok   = (col_ff != n_m1);
            nb_addr = cell_ff + ADDR_W'(1);
         end
         DIR_DOWN: begin
            nb_ok   = (row_ff != n_m1);
            nb_addr = cell_ff + n_a;
         end
         default: begin
            nb_ok   = (col_ff != '0);
            nb_addr = cell_ff - ADDR_W'(1);
         end
      endcase
   end

   // Root already counted for this water cell
   always_comb begin
      dup = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if ((3'(i) < seen_cnt_ff) && (seen_ff[i] == cur_ff)) dup = 1'b1;
      end
   end

   // Union by size
   assign link_sum   = sa_ff + siz_q;
   assign small_root = (sa_ff < siz_q) ? ra_ff : rb_ff;
   assign big_root   = (sa_ff < siz_q) ? rb_ff : ra_ff;

   assign advance = (cmd == C_INIT) || (cmd == C_NEXT) || (cmd == C_FIN) ||
                    (cmd == C_SCAN_CMP);

   // Read address selection
   always_comb begin
      img_raddr = cell_ff;
      par_raddr = cell_ff;
      siz_raddr = cell_ff;
      unique case (cmd)
         C_RD_NB:            img_raddr = nb_addr;
         C_SAVE_A, C_FIND_NB: par_raddr = nb_addr;
         C_HOP:              par_raddr = par_q;
         C_SIZE_A:           siz_raddr = ra_ff;
         C_SIZE_B:           siz_raddr = rb_ff;
         C_SIZE_R:           siz_raddr = cur_ff;
         default: ;
      endcase
   end

   // Memory ports
   always_ff @(posedge clock) begin
      if ((cmd == C_LOAD) || (cmd == C_LOADLAST)) img_mem[pcount_ff] <= req_pixel;
      if (cmd == C_INIT) begin
         par_mem[cell_ff] <= cell_ff;
         siz_mem[cell_ff] <= SIZE_W'(1);
      end
      if (cmd == C_LINK) begin
         par_mem[small_root] <= big_root;
         siz_mem[big_root]   <= link_sum;
      end
      img_q <= img_mem[img_raddr];
      par_q <= par_mem[par_raddr];
      siz_q <= siz_mem[siz_raddr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= SIDE_W'(SIDE_RESET);
         pcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            side_ff   <= csr_write_data;
            pcount_ff <= '0;
         end else if (cmd == C_LOAD) begin
            pcount_ff <= pcount_ff + ADDR_W'(1);
         end else if (cmd == C_LOADLAST) begin
            pcount_ff <= '0;
         end
         if (cmd == C_EMIT)  rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd == C_LOADLAST) begin
         cell_ff <= '0;
         row_ff  <= '0;
         col_ff  <= '0;
         best_ff <= '0;
      end else if (advance) begin
         if (CNT_W'(cell_ff) == last_idx) begin
            cell_ff <= '0;
            row_ff  <= '0;
            col_ff  <= '0;
         end else begin
            cell_ff <= cell_ff + ADDR_W'(1);
            if (col_ff == n_m1) begin
               col_ff <= '0;
               row_ff <= row_ff + NW'(1);
            end else begin
               col_ff <= col_ff + NW'(1);
            end
         end
      end
      case (cmd)
         C_RD_HERE_U: k_ff <= DIR_RIGHT;
         C_RD_HERE_E: begin
            k_ff        <= DIR_UP;
            seen_cnt_ff <= '0;
            sum_ff      <= SIZE_W'(1);
         end
         C_KINC:      k_ff <= k_ff + 2'd1;
         C_FIND_HERE: cur_ff <= cell_ff;
         C_FIND_NB:   cur_ff <= nb_addr;
         C_HOP:       cur_ff <= par_q;
         C_SAVE_A: begin
            ra_ff  <= cur_ff;
            cur_ff <= nb_addr;
         end
         C_SIZE_A:    rb_ff <= cur_ff;
         C_SIZE_B:    sa_ff <= siz_q;
         C_SIZE_R: begin
            seen_ff[seen_cnt_ff[1:0]] <= cur_ff;
            seen_cnt_ff               <= seen_cnt_ff + 3'd1;
         end
         C_ADD:       sum_ff <= sum_ff + siz_q;
         C_FIN:       if (sum_ff > best_ff) best_ff <= sum_ff;
         C_SCAN_CMP:  if ((par_q == cell_ff) && (siz_q > best_ff)) best_ff <= siz_q;
         C_EMIT:      rsp_data_ff <= OUT_W'(best_ff);
         default: ;
      endcase
   end

   // Status back to the controller
   assign stat.last_pix  = (CNT_W'(pcount_ff) == last_idx);
   assign stat.cell_last = (CNT_W'(cell_ff) == last_idx);
   assign stat.img_bit   = img_q;
   assign stat.nb_ok     = nb_ok;
   assign stat.k         = k_ff;
   assign stat.found     = (par_q == cur_ff);
   assign stat.same      = (ra_ff == rb_ff);
   assign stat.dup       = dup;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_largest_size = rsp_data_ff;

endmodule

FILE: sv/largest_island_after_one_flip.sv
// Channel | Ports                                   | Beat
// req     | req_valid, req_ready, req_pixel         | one pixel, row-major order
// rsp     | rsp_valid, rsp_ready, rsp_largest_size  | one result per image
// csr     | csr_write_enable, csr_write_data        | side length, no wait
//
// Each pixel beat is stored as it is taken; the last pixel starts the evaluation, input held off.
// Evaluation: an init pass over all n*n cells; a union pass over the right/down neighbors of each
// land cell, a flip pass over all neighbors of each water cell, each find hopping to its root; a root scan.
// Reset is synchronous, active high; the stores are written before they are read.
// The result sits in an output register, so pixels of the next image are taken while it
// waits; a stalled result holds the block only at the end of that image.
module largest_island_after_one_flip import lia_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [SIDE_W-1:0] csr_write_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_pixel,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [OUT_W-1:0]  rsp_largest_size
);

`include "largest_island_after_one_flip_macros.svh"

   ctrl_type   ctrl;
   status_type stat;

   lia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   lia_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_pixel        (req_pixel),
      .rsp_ready        (rsp_ready),
      .ctrl             (ctrl),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_largest_size (rsp_largest_size)
   );

   // Checks
   `LIA_CHECK(a_beat_loads, req_valid && req_ready, (ctrl.cmd == C_LOAD) || (ctrl.cmd == C_LOADLAST), "accepted pixel not stored")
   `LIA_CHECK(a_emit_free, ctrl.cmd == C_EMIT, stat.out_free, "result overwrites a waiting result")
   `LIA_CHECK_NEXT(a_emit_valid, ctrl.cmd == C_EMIT, rsp_valid && (rsp_largest_size != '0), "emitted result missing or zero")

endmodule
